@@ rtl/spcps_pkg.sv @@
// shared constants and types for the sparse column permute sort block
// no dependencies
`default_nettype none
package spcps_pkg;
   localparam int VecLenDef   = 1024;
   localparam int MaxNnzDef   = 64;
   localparam int ElemBitsDef = 64;
   localparam int COL_W       = 10;
   localparam int VAL_W       = 64;
   localparam int MODE_W      = 2;
   localparam int REQ_DATA_W  = 88;
   localparam int RSP_DATA_W  = 80;

   typedef enum logic [MODE_W-1:0] {
      MODE_PERM = 2'd0,
      MODE_LOAD = 2'd1,
      MODE_EMIT = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;
endpackage
`default_nettype wire

@@ rtl/spcps_ram.sv @@
// generic single-port-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module spcps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

@@ rtl/sparse_column_permute_sort.sv @@
// sparse column permute sort top level: permutation table, nonzero store and emitter
// depends on spcps_pkg and spcps_ram
//
// usage:
//   req channel carries one request per handshake: mode 0 writes a permutation
//   table entry, mode 1 appends a nonzero, mode 2 sorts and emits the store.
//   rsp channel returns the sorted nonzeros, lowest new column first, tlast on
//   the final one. mode 3 and out-of-range requests are dropped.
// throughput and emit sequence:
//   mode 0 and mode 1 requests are taken one per cycle while the block is idle.
//   a mode 2 request with n nonzeros first maps each column through the table
//   ram for each nonzero (column read, table read, key write), then runs n
//   selection passes over the store rams, emitting one result per pass;
//   an empty store emits nothing. the minimum search in each pass reads one
//   store entry per cycle.
// reset:
//   clears the nonzero count and control state; the rams hold no reset value.
// stall:
//   a stalled result holds in the output register and the next selected result
//   waits for it; no request is taken until the last result is loaded.
`default_nettype none
module sparse_column_permute_sort
   import spcps_pkg::*;
#(
   parameter int VEC_LEN   = VecLenDef,
   parameter int MAX_NNZ   = MaxNnzDef,
   parameter int ELEM_BITS = ElemBitsDef
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // mode[1:0], column[11:2], target_column[21:12], entry_value[85:22], zero fill
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // new_column[9:0], out_value[73:10], zero fill
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast
);
   localparam int TAB_D = (VEC_LEN > (1 << COL_W)) ? (1 << COL_W) : VEC_LEN;
   localparam int TAB_A = $clog2(TAB_D);
   localparam int NZ_A  = (MAX_NNZ > 1) ? $clog2(MAX_NNZ) : 1;
   localparam int NZ_D  = 1 << NZ_A;
   localparam int CNT_W = NZ_A + 1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MAP_RD, ST_MAP_TAB, ST_MAP_WR, ST_SCAN, ST_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [MODE_W-1:0] req_mode;
   logic [COL_W-1:0]  req_col, req_tgt;
   logic [VAL_W-1:0]  req_val;
   assign req_mode = req_tdata[1:0];
   assign req_col  = req_tdata[11:2];
   assign req_tgt  = req_tdata[21:12];
   assign req_val  = req_tdata[85:22];

   logic req_fire;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   logic col_ok, tgt_ok;
   assign col_ok = ({22'd0, req_col} < 32'(VEC_LEN));
   assign tgt_ok = ({22'd0, req_tgt} < 32'(VEC_LEN));

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] idx_ff, idx_in;     // map index / scan index
   logic [CNT_W-1:0] pass_ff, pass_in;   // results emitted
   logic [NZ_D-1:0]  used_ff, used_in;
   logic [COL_W-1:0] best_key_ff, best_key_in;
   logic [NZ_A-1:0]  best_idx_ff, best_idx_in;
   logic             best_ok_ff, best_ok_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [NZ_A-1:0]  rd_idx_ff, rd_idx_in;
   logic             rsp_tvalid_ff, rsp_tvalid_in;
   logic             rsp_tlast_ff, rsp_tlast_in;
   logic [COL_W-1:0] rsp_col_ff, rsp_col_in;

   // table ram
   logic             tab_we;
   logic [TAB_A-1:0] tab_wa, tab_ra;
   logic [COL_W-1:0] tab_rd;
   // column, key and value rams
   logic             col_we, key_we, val_we;
   logic [NZ_A-1:0]  col_wa, key_wa, nz_ra;
   logic [COL_W-1:0] col_rd, key_rd;
   logic [VAL_W-1:0] val_wd, val_rd;

   logic load_ok;
   assign load_ok = (req_mode == MODE_LOAD) && col_ok && (cnt_ff < CNT_W'(MAX_NNZ));

   assign tab_we = req_fire && (req_mode == MODE_PERM) && col_ok && tgt_ok;
   assign tab_wa = req_col[TAB_A-1:0];
   assign tab_ra = col_rd[TAB_A-1:0];
   assign col_we = req_fire && load_ok;
   assign col_wa = cnt_ff[NZ_A-1:0];
   assign val_we = col_we;
   assign val_wd = req_val & (~64'd0 >> (64 - ELEM_BITS));
   assign key_we = (state_ff == ST_MAP_WR);
   assign key_wa = idx_ff[NZ_A-1:0];

   always_comb begin
      nz_ra = idx_ff[NZ_A-1:0];
      if (state_ff == ST_OUT
          || (state_ff == ST_SCAN && idx_ff == cnt_ff && !rd_vld_ff)) begin
         nz_ra = best_idx_ff;
      end
   end

   spcps_ram #(.WIDTH(COL_W), .DEPTH(TAB_D)) u_tab (
      .clock(clock), .wr_en(tab_we), .wr_addr(tab_wa), .wr_data(req_tgt),
      .rd_addr(tab_ra), .rd_data(tab_rd));
   spcps_ram #(.WIDTH(COL_W), .DEPTH(NZ_D)) u_col (
      .clock(clock), .wr_en(col_we), .wr_addr(col_wa), .wr_data(req_col),
      .rd_addr(nz_ra), .rd_data(col_rd));
   spcps_ram #(.WIDTH(COL_W), .DEPTH(NZ_D)) u_key (
      .clock(clock), .wr_en(key_we), .wr_addr(key_wa), .wr_data(tab_rd),
      .rd_addr(nz_ra), .rd_data(key_rd));
   spcps_ram #(.WIDTH(VAL_W), .DEPTH(NZ_D)) u_val (
      .clock(clock), .wr_en(val_we), .wr_addr(col_wa), .wr_data(val_wd),
      .rd_addr(nz_ra), .rd_data(val_rd));

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      pass_in       = pass_ff;
      used_in       = used_ff;
      best_key_in   = best_key_ff;
      best_idx_in   = best_idx_ff;
      best_ok_in    = best_ok_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = idx_ff[NZ_A-1:0];
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      rsp_col_in    = rsp_col_ff;
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (load_ok) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               if (req_mode == MODE_EMIT && cnt_ff != '0) begin
                  idx_in   = '0;
                  state_in = ST_MAP_RD;
               end
            end
         end
         ST_MAP_RD: begin
            // column ram read in flight
            state_in = ST_MAP_TAB;
         end
         ST_MAP_TAB: begin
            // column ram data valid now, table read in flight
            state_in = ST_MAP_WR;
         end
         ST_MAP_WR: begin
            if (idx_ff + 1'b1 == cnt_ff) begin
               idx_in     = '0;
               pass_in    = '0;
               used_in    = '0;
               best_ok_in = 1'b0;
               state_in   = ST_SCAN;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_MAP_RD;
            end
         end
         ST_SCAN: begin
            if (idx_ff < cnt_ff) begin
               rd_vld_in = 1'b1;
               idx_in    = idx_ff + 1'b1;
            end
            if (rd_vld_ff && !used_ff[rd_idx_ff]
                && (!best_ok_ff || key_rd < best_key_ff)) begin
               best_ok_in  = 1'b1;
               best_key_in = key_rd;
               best_idx_in = rd_idx_ff;
            end
            if (idx_ff == cnt_ff && !rd_vld_ff) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // value ram read of best entry issued on entry; wait for output slot
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_col_in    = best_key_ff;
               rsp_tlast_in  = (pass_ff + 1'b1 == cnt_ff);
               used_in[best_idx_ff] = 1'b1;
               best_ok_in    = 1'b0;
               idx_in        = '0;
               pass_in       = pass_ff + 1'b1;
               if (pass_ff + 1'b1 == cnt_ff) begin
                  cnt_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   logic [VAL_W-1:0] rsp_val_ff;
   logic             out_load;
   assign out_load = (state_ff == ST_OUT) && (!rsp_tvalid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         idx_ff        <= '0;
         pass_ff       <= '0;
         used_ff       <= '0;
         best_ok_ff    <= 1'b0;
         rd_vld_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         rsp_tlast_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         idx_ff        <= idx_in;
         pass_ff       <= pass_in;
         used_ff       <= used_in;
         best_ok_ff    <= best_ok_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         rsp_tlast_ff  <= rsp_tlast_in;
      end
      best_key_ff <= best_key_in;
      best_idx_ff <= best_idx_in;
      rd_idx_ff   <= rd_idx_in;
      rsp_col_ff  <= rsp_col_in;
      if (out_load) begin
         rsp_val_ff <= val_rd;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tdata  = {6'd0, rsp_val_ff, rsp_col_ff};
endmodule
`default_nettype wire

@@ rtl/spcps_checker.sv @@
// port-level checks for sparse_column_permute_sort, bound to the top level
// depends on sparse_column_permute_sort ports
`default_nettype none
module spcps_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [87:0] req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [79:0] rsp_tdata,
   input wire logic        rsp_tlast
);
   // no request is taken while more results of an emit are pending
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready) else $error("request taken during emit");
   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
      && $stable(rsp_tlast)) else $error("stalled result changed");
   // a non-last result is followed by more results before new requests
   a_more: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> !req_tready)
      else $error("emit ended without last");
   // zero fill stays zero
   a_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[79:74] == 6'd0) else $error("fill bits set");
endmodule

bind sparse_column_permute_sort spcps_checker u_spcps_checker (.*);
`default_nettype wire

@@ verif/tb_sparse_column_permute_sort.sv @@
// testbench for sparse_column_permute_sort: drives permutation, load and emit requests
// with random idling on both channels and checks sorted results against a scoreboard
// depends on spcps_pkg and the sparse_column_permute_sort rtl
`timescale 1ns / 1ps
module tb_sparse_column_permute_sort;
   import spcps_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;

   class permute_scoreboard;
      bit [COL_W-1:0] col_map [1024];
      bit             col_written [1024];
      bit [COL_W-1:0] held_cols [$];
      bit [VAL_W-1:0] held_vals [$];
      bit [COL_W-1:0] exp_col [$];
      bit [VAL_W-1:0] exp_val [$];
      bit             exp_last [$];
      int             errors;
      int             checked;

      function void note_request(mode_type m, bit [COL_W-1:0] c, bit [COL_W-1:0] t,
                                 bit [VAL_W-1:0] v);
         bit [COL_W-1:0] keys [$];
         bit [VAL_W-1:0] vals [$];
         bit [COL_W-1:0] k;
         bit [VAL_W-1:0] kv;
         int j;
         case (m)
            MODE_PERM: begin
               col_map[c] = t;
               col_written[c] = 1;
            end
            MODE_LOAD: begin
               if (held_cols.size() < MaxNnzDef) begin
                  held_cols.push_back(c);
                  held_vals.push_back(v);
               end
            end
            MODE_EMIT: begin
               foreach (held_cols[i]) begin
                  k = col_map[held_cols[i]];
                  kv = held_vals[i];
                  j = keys.size();
                  while (j > 0 && keys[j-1] > k) j--;
                  keys.insert(j, k);
                  vals.insert(j, kv);
               end
               foreach (keys[i]) begin
                  exp_col.push_back(keys[i]);
                  exp_val.push_back(vals[i]);
                  exp_last.push_back(i == keys.size() - 1);
               end
               held_cols.delete();
               held_vals.delete();
            end
            default: ;
         endcase
      endfunction

      function void check_result(bit [COL_W-1:0] c, bit [VAL_W-1:0] v, bit l);
         checked++;
         if (exp_col.size() == 0) begin
            $display("%0t: unexpected result col %0d value %h last %0b", $time, c, v, l);
            errors++;
            return;
         end
         if (c !== exp_col[0] || v !== exp_val[0] || l !== exp_last[0]) begin
            $display("%0t: mismatch expected col %0d value %h last %0b, got %0d %h %0b",
                     $time, exp_col[0], exp_val[0], exp_last[0], c, v, l);
            errors++;
         end
         void'(exp_col.pop_front());
         void'(exp_val.pop_front());
         void'(exp_last.pop_front());
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   permute_scoreboard board;
   int  cycles;
   bit  calm;
   int  requests_sent;

   sparse_column_permute_sort dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      board = new();
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      rsp_tready = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (!reset)
         rsp_tready <= calm || ($urandom_range(99) >= 16);
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata[9:0], rsp_tdata[73:10], rsp_tlast);
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic send_request(mode_type m, bit [COL_W-1:0] c, bit [COL_W-1:0] t,
                               bit [VAL_W-1:0] v);
      while (!calm && $urandom_range(99) < 16) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {2'b0, v, t, c, m};
      @(posedge clock iff req_tready);
      board.note_request(m, c, t, v);
      requests_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      while (board.exp_col.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // random table rewrites; repeated targets give key ties
   task automatic write_permutation(int count);
      bit [COL_W-1:0] t;
      for (int i = 0; i < count; i++) begin
         t = COL_W'($urandom_range(1023));
         send_request(MODE_PERM, COL_W'($urandom_range(1023)), t, '0);
      end
   endtask

   task automatic load_random(int n, bit restrict_cols);
      bit [COL_W-1:0] c;
      for (int i = 0; i < n; i++) begin
         c = restrict_cols ? COL_W'($urandom_range(7)) : COL_W'($urandom_range(1023));
         if (!board.col_written[c])
            send_request(MODE_PERM, c, COL_W'($urandom_range(1023)), '0);
         send_request(MODE_LOAD, c, COL_W'($urandom_range(1023)), {$urandom, $urandom});
      end
   endtask

   initial begin
      @(negedge reset);
      @(posedge clock);
      // directed: extremes, every mode, stable ties, empty store, unused mode, full store
      send_request(MODE_PERM, '0, '1, '0);
      send_request(MODE_PERM, '1, '0, '0);
      send_request(MODE_PERM, COL_W'(5), '1, '0);
      send_request(MODE_EMIT, '0, '0, '0);
      send_request(MODE_LOAD, '0, '0, '1);
      send_request(MODE_LOAD, '1, '1, '0);
      send_request(MODE_LOAD, COL_W'(5), '0, 64'h8000_0000_0000_0001);
      send_request(MODE_NONE, '1, '1, '1);
      send_request(MODE_EMIT, '1, '1, '1);
      send_request(MODE_EMIT, '0, '0, '0);
      wait_drained();
      calm = 1;
      load_random(64, 0);
      send_request(MODE_LOAD, COL_W'(3), COL_W'(3), '1);
      send_request(MODE_EMIT, '0, '0, '0);
      wait_drained();
      calm = 0;
      // random phase
      write_permutation(20);
      while (requests_sent < 212) begin
         load_random($urandom_range(1, 8), 1'($urandom_range(1)));
         if ($urandom_range(9) == 0)
            send_request(MODE_NONE, COL_W'($urandom), COL_W'($urandom), {$urandom, $urandom});
         send_request(MODE_EMIT, COL_W'($urandom), COL_W'($urandom), {$urandom, $urandom});
         if ($urandom_range(7) == 0) wait_drained();
      end
      wait_drained();
      repeat (100) @(posedge clock);
      $display("covered %0d requests and %0d results, ties, full store, empty emits",
               requests_sent, board.checked);
      if (board.errors == 0 && board.exp_col.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
rtl/spcps_pkg.sv
rtl/spcps_ram.sv
rtl/sparse_column_permute_sort.sv
rtl/spcps_checker.sv
verif/tb_sparse_column_permute_sort.sv
